// ===== rtl/prws_pkg.sv =====
// shared types and constants of the priority ready/wait scheduler
// no dependencies; used by every module of the block except prws_ram
package prws_pkg;

	// default sizes, handed down as top-level parameter defaults
	localparam int LEVELS_DEF     = 6;
	localparam int TASK_SLOTS_DEF = 16;

	// fixed field widths
	localparam int ID_W  = 4;
	localparam int LVL_W = 3;
	localparam int ST_W  = 2;

	// operation codes
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] ST_ADDED  = 2'd0;
	localparam logic [ST_W-1:0] ST_RUN    = 2'd1;
	localparam logic [ST_W-1:0] ST_IDLE   = 2'd2;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd3;

	// request transaction payload
	typedef struct packed {
		logic             operation;
		logic [ID_W-1:0]  task_id;
		logic [LVL_W-1:0] priority_req;
		logic             blocks;
	} req_item_t;

	// response transaction payload
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [ID_W-1:0]  run_id;
		logic [LVL_W-1:0] run_level;
		logic             woke;
		logic [ID_W-1:0]  woke_id;
	} rsp_item_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_PUSH,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic decode;
		logic pop;
		logic push;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_add;
		logic run_empty;
		logic blocks;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/prws_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
module prws_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/prws_ctrl.sv =====
// controller state machine of the scheduler: sequences add and run steps
// depends on prws_pkg
module prws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  prws_pkg::dp_stat_t   stat,
	output prws_pkg::ctrl_cmd_t  cmd
);

	prws_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prws_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			prws_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = prws_pkg::S_DECODE;
				end
			end
			prws_pkg::S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.is_add || stat.run_empty) begin
					state_d = prws_pkg::S_DONE;
				end else begin
					state_d = prws_pkg::S_POP;
				end
			end
			prws_pkg::S_POP: begin
				cmd.pop = 1'b1;
				if (stat.blocks) begin
					state_d = prws_pkg::S_PUSH;
				end else begin
					state_d = prws_pkg::S_DONE;
				end
			end
			prws_pkg::S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = prws_pkg::S_DONE;
			end
			prws_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = prws_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = prws_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/prws_dp.sv =====
// datapath of the scheduler: per-level list heads, busy bits, link RAM, result
// depends on prws_pkg and prws_ram
module prws_dp #(
	parameter int LEVELS     = prws_pkg::LEVELS_DEF,
	parameter int TASK_SLOTS = prws_pkg::TASK_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  prws_pkg::req_item_t  req_data,
	output prws_pkg::rsp_item_t  rsp_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  prws_pkg::ctrl_cmd_t  cmd,
	output prws_pkg::dp_stat_t   stat
);

	localparam int LV_W  = $clog2(LEVELS);
	localparam int IDX_W = $clog2(TASK_SLOTS);

	// list heads and tails per level
	logic [prws_pkg::ID_W-1:0] rdy_first_q [LEVELS];
	logic [prws_pkg::ID_W-1:0] rdy_last_q  [LEVELS];
	logic [prws_pkg::ID_W-1:0] blk_first_q [LEVELS];
	logic [prws_pkg::ID_W-1:0] blk_last_q  [LEVELS];
	logic [LEVELS-1:0]         rdy_ne_q;
	logic [LEVELS-1:0]         blk_ne_q;
	logic [TASK_SLOTS-1:0]     busy_q;

	// working registers of the step in progress
	prws_pkg::req_item_t       in_q;
	prws_pkg::rsp_item_t       res_q;
	prws_pkg::rsp_item_t       res_d;
	prws_pkg::rsp_item_t       out_q;
	logic                      out_valid_q;
	logic [prws_pkg::ID_W-1:0] tid_q;
	logic [LV_W-1:0]           lvl_q;
	logic                      sel_blk_q;

	logic                      is_add;
	logic                      add_ok;
	logic [IDX_W-1:0]          add_idx;
	logic [LV_W-1:0]           add_lvl;
	logic                      rdy_hit;
	logic                      blk_hit;
	logic [LV_W-1:0]           rdy_lvl;
	logic [LV_W-1:0]           blk_lvl;
	logic [LV_W-1:0]           run_lvl;
	logic [prws_pkg::ID_W-1:0] run_tid;
	logic                      run_go;
	logic                      pop_last;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [prws_pkg::ID_W-1:0] ram_wdata;
	logic [prws_pkg::ID_W-1:0] ram_rdata;

	// add decode: range and busy check, level saturation
	assign is_add  = (in_q.operation == prws_pkg::OP_ADD);
	assign add_idx = IDX_W'(in_q.task_id);
	assign add_ok  = (32'(in_q.task_id) < TASK_SLOTS) && !busy_q[add_idx];
	assign add_lvl = (32'(in_q.priority_req) >= LEVELS) ? LV_W'(LEVELS - 1)
	                                                    : LV_W'(in_q.priority_req);

	// lowest-numbered nonempty level of each set
	always_comb begin
		rdy_lvl = '0;
		blk_lvl = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (rdy_ne_q[l]) begin
				rdy_lvl = LV_W'(l);
			end
			if (blk_ne_q[l]) begin
				blk_lvl = LV_W'(l);
			end
		end
	end

	assign rdy_hit = |rdy_ne_q;
	assign blk_hit = |blk_ne_q;

	// run selection: ready head, or oldest blocked task woken straight into dispatch
	assign run_lvl = rdy_hit ? rdy_lvl : blk_lvl;
	assign run_tid = rdy_hit ? rdy_first_q[rdy_lvl] : blk_first_q[blk_lvl];
	assign run_go  = cmd.decode && !is_add && (rdy_hit || blk_hit);

	// head of the popped list is its last entry
	assign pop_last = sel_blk_q ? (tid_q == blk_last_q[lvl_q])
	                            : (tid_q == rdy_last_q[lvl_q]);

	// result of the decoded transaction
	always_comb begin
		res_d = '0;
		if (is_add) begin
			res_d.status = add_ok ? prws_pkg::ST_ADDED : prws_pkg::ST_REJECT;
		end else if (!rdy_hit && !blk_hit) begin
			res_d.status = prws_pkg::ST_IDLE;
		end else begin
			res_d.status    = prws_pkg::ST_RUN;
			res_d.run_id    = run_tid;
			res_d.run_level = prws_pkg::LVL_W'(run_lvl);
			res_d.woke      = !rdy_hit;
			res_d.woke_id   = rdy_hit ? '0 : run_tid;
		end
	end

	// link RAM write port: add append or blocked append
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(rdy_last_q[add_lvl]);
		ram_wdata = in_q.task_id;
		if (cmd.decode && is_add && add_ok && rdy_ne_q[add_lvl]) begin
			ram_we = 1'b1;
		end
		if (cmd.push && blk_ne_q[lvl_q]) begin
			ram_we    = 1'b1;
			ram_waddr = IDX_W'(blk_last_q[lvl_q]);
			ram_wdata = tid_q;
		end
	end

	prws_ram #(
		.WIDTH(prws_pkg::ID_W),
		.DEPTH(TASK_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (run_go),
		.raddr(IDX_W'(run_tid)),
		.rdata(ram_rdata)
	);

	// control state: nonempty flags, busy bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_ne_q    <= '0;
			blk_ne_q    <= '0;
			busy_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decode && is_add && add_ok) begin
				rdy_ne_q[add_lvl] <= 1'b1;
				busy_q[add_idx]   <= 1'b1;
			end
			if (cmd.pop) begin
				if (pop_last) begin
					if (sel_blk_q) begin
						blk_ne_q[lvl_q] <= 1'b0;
					end else begin
						rdy_ne_q[lvl_q] <= 1'b0;
					end
				end
				if (!in_q.blocks) begin
					busy_q[IDX_W'(tid_q)] <= 1'b0;
				end
			end
			if (cmd.push) begin
				blk_ne_q[lvl_q] <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= req_data;
		end
		if (cmd.decode) begin
			res_q <= res_d;
			if (is_add && add_ok) begin
				rdy_last_q[add_lvl] <= in_q.task_id;
				if (!rdy_ne_q[add_lvl]) begin
					rdy_first_q[add_lvl] <= in_q.task_id;
				end
			end
			tid_q     <= run_tid;
			lvl_q     <= run_lvl;
			sel_blk_q <= !rdy_hit;
		end
		// pop: advance the head past the dispatched task
		if (cmd.pop && !pop_last) begin
			if (sel_blk_q) begin
				blk_first_q[lvl_q] <= ram_rdata;
			end else begin
				rdy_first_q[lvl_q] <= ram_rdata;
			end
		end
		// push: append the blocking task to its level's blocked list
		if (cmd.push) begin
			blk_last_q[lvl_q] <= tid_q;
			if (!blk_ne_q[lvl_q]) begin
				blk_first_q[lvl_q] <= tid_q;
			end
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp_data       = out_q;
	assign rsp_valid      = out_valid_q;
	assign stat.is_add    = is_add;
	assign stat.run_empty = !rdy_hit && !blk_hit;
	assign stat.blocks    = in_q.blocks;
	assign stat.out_free  = !out_valid_q || rsp_ready;

endmodule

// ===== rtl/priority_ready_wait_scheduler_unit.sv =====
// Priority ready/wait scheduler, top level.
// Steps: an add passes through decode and then the output load; a run that finds
// a task adds the link read and pop, and a blocked append when that task blocks.
// One transaction at a time: a new request is taken only after the last result is
// loaded into the output register; pops and appends share the link RAM.
// Reset: all lists empty and all ids free at once; no clearing pass.
module priority_ready_wait_scheduler_unit #(
	parameter int LEVELS     = prws_pkg::LEVELS_DEF,
	parameter int TASK_SLOTS = prws_pkg::TASK_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  prws_pkg::req_item_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output prws_pkg::rsp_item_t rsp_data
);

	prws_pkg::ctrl_cmd_t cmd;
	prws_pkg::dp_stat_t  stat;

	// sequencing
	prws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// lists, link storage and result register
	prws_dp #(
		.LEVELS    (LEVELS),
		.TASK_SLOTS(TASK_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.rsp_data (rsp_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
